>>> src/rdz_pkg.sv
// Package: shared widths, constants and helpers for the radial dead-zone block
`default_nettype none
package rdz_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int THR_W = 17;
  localparam int LEN_W = 18;
  localparam int SQ_W = 34;
  localparam int MAG_W = 16;
  localparam int CW = 28;
  localparam int DIV_W = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [0:0] REG_INNER = 1'b0;
  localparam logic [0:0] REG_OUTER = 1'b1;

  typedef enum logic [1:0] {
    MAP_ZERO = 2'b01,
    MAP_DIV  = 2'b10
  } map_kind_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [LEN_W-1:0] len;
    logic [15:0] mag;
    logic is_zero;
    logic need_div;
    logic [LEN_W-1:0] num;
    logic [THR_W-1:0] den;
  } item_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

>>> src/radial_deadzone_joystick.sv
// Top level: radial dead-zone correction for an analog stick
// The path from the start transfer to done runs through the sqrt, two divides and the CORDIC.
// Throughput: one sample per cycle; every pipeline stage advances each cycle.
// The queue between front and back is drained every cycle, so it never fills.
// Reset: synchronous rst clears valid flags and sets thresholds to 0 and 1.0.
// Results cannot be stalled; done marks each result for one cycle.
`default_nettype none
module radial_deadzone_joystick
  import rdz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [15:0] raw_x,
  input  wire logic signed [15:0] raw_y,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [THR_W-1:0] cfg_data,
  output logic done,
  output logic signed [15:0] corrected_x,
  output logic signed [15:0] corrected_y,
  output logic [15:0] corrected_magnitude,
  output logic [15:0] stick_angle
);
  logic [THR_W-1:0] inner_threshold, outer_threshold;
  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_threshold <= '0;
      outer_threshold <= THR_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER: inner_threshold <= cfg_data;
        REG_OUTER: outer_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic fv, qne;
  item_t fi, qi;
  rdz_front u_front (.clk(clk), .rst(rst), .in_valid(start), .x(raw_x), .y(raw_y),
    .inner(inner_threshold), .outer(outer_threshold), .out_valid(fv), .out_item(fi));
  rdz_queue u_queue (.clk(clk), .rst(rst), .push(fv), .din(fi), .pop(1'b1),
    .not_empty(qne), .dout(qi));
  rdz_back u_back (.clk(clk), .rst(rst), .in_valid(qne), .it(qi), .done(done),
    .cx(corrected_x), .cy(corrected_y), .cmag(corrected_magnitude),
    .angle(stick_angle));
endmodule
`default_nettype wire

>>> src/rdz_sqrt.sv
// Pipelined integer square root, one result bit per stage
`default_nettype none
module rdz_sqrt
  import rdz_pkg::*;
(
  input  wire logic clk,
  input  wire logic [SQ_W-1:0] sq,
  output logic [LEN_W-1:0] root
);
  localparam int NB = SQ_W / 2;
  logic [SQ_W-1:0] rem [0:NB];
  logic [NB-1:0] res [0:NB];

  assign rem[0] = sq;
  assign res[0] = '0;

  // Decide one root bit per stage, most significant first
  for (genvar k = 0; k < NB; k++) begin : g_st
    logic [SQ_W-1:0] trial;
    logic [NB-1:0] rb;
    logic [SQ_W+1:0] tw;
    assign rb = res[k] | (NB'(1) << (NB-1-k));
    assign tw = (SQ_W+2)'(rb) * (SQ_W+2)'(rb);
    always_ff @(posedge clk) begin
      rem[k+1] <= rem[k];
      if (tw <= (SQ_W+2)'(rem[k])) res[k+1] <= rb;
      else res[k+1] <= res[k];
    end
  end
  assign root = LEN_W'(res[NB]);
endmodule
`default_nettype wire

>>> src/rdz_front.sv
// Front end: square root, threshold compare and item classification
`default_nettype none
module rdz_front
  import rdz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic [THR_W-1:0] inner,
  input  wire logic [THR_W-1:0] outer,
  output logic out_valid,
  output item_t out_item
);
  localparam int SL = SQ_W / 2;
  logic [SQ_W-1:0] sq;
  logic [LEN_W-1:0] root;
  logic [SL-1:0] vld;
  logic signed [15:0] xs [0:SL-1];
  logic signed [15:0] ys [0:SL-1];
  logic [31:0] xx, yy;

  always_ff @(posedge clk) begin
    xx <= 32'(x * x);
    yy <= 32'(y * y);
  end
  assign sq = {SQ_W'(xx) + SQ_W'(yy)} << 2;

  rdz_sqrt u_sqrt (.clk(clk), .sq(sq), .root(root));

  // Carry samples alongside the square root
  logic v0;
  logic signed [15:0] x0, y0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; vld <= '0;
    end else begin
      v0 <= in_valid;
      vld <= {vld[SL-2:0], v0};
    end
    x0 <= x; y0 <= y;
    xs[0] <= x0; ys[0] <= y0;
    for (int k = 1; k < SL; k++) begin
      xs[k] <= xs[k-1]; ys[k] <= ys[k-1];
    end
  end

  // Classify the length against the thresholds
  logic [LEN_W-1:0] li, lo;
  map_kind_t kind;
  logic [15:0] mag;
  always_comb begin
    li = LEN_W'(inner);
    lo = LEN_W'(outer);
    kind = MAP_ZERO;
    mag = '0;
    if (root <= li) begin
      kind = MAP_ZERO;
      mag = '0;
    end else if (lo <= li || root >= lo) begin
      kind = MAP_ZERO;
      mag = ONE_Q15;
    end else begin
      kind = MAP_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[SL-1];
    out_item.x <= xs[SL-1];
    out_item.y <= ys[SL-1];
    out_item.len <= root;
    out_item.mag <= mag;
    out_item.is_zero <= (xs[SL-1] == 0) && (ys[SL-1] == 0);
    out_item.need_div <= (kind == MAP_DIV);
    out_item.num <= root - li;
    out_item.den <= THR_W'(outer - inner);
  end
endmodule
`default_nettype wire

>>> src/rdz_queue.sv
// Short queue between front and back ends
`default_nettype none
module rdz_queue
  import rdz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire item_t din,
  input  wire logic pop,
  output logic not_empty,
  output item_t dout
);
  item_t mem [0:QDEPTH-1];
  logic [QPTR_W:0] wp, rp;
  assign not_empty = (wp != rp);
  assign dout = mem[rp[QPTR_W-1:0]];
  // Advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop && not_empty) rp <= rp + 1'b1;
    end
    if (push) mem[wp[QPTR_W-1:0]] <= din;
  end
endmodule
`default_nettype wire

>>> src/rdz_back.sv
// Back end: pipelined divides, rebuild of X and Y, CORDIC angle
`default_nettype none
module rdz_back
  import rdz_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire item_t it,
  output logic done,
  output logic signed [15:0] cx,
  output logic signed [15:0] cy,
  output logic [15:0] cmag,
  output logic [15:0] angle
);
  // Stage group A: restoring divide for the mapped magnitude (16 quotient bits + 1)
  localparam int QA = 17;
  logic [DIV_W-1:0] ra [0:QA];
  logic [QA-1:0] qa [0:QA];
  item_t ia [0:QA];
  logic va [0:QA];
  assign va[0] = in_valid;
  assign ia[0] = it;
  assign ra[0] = (DIV_W'(it.num) << 15) + DIV_W'(it.den >> 1);
  assign qa[0] = '0;
  for (genvar k = 0; k < QA; k++) begin : g_da
    logic [DIV_W+QA-1:0] dsh;
    assign dsh = (DIV_W+QA)'(ia[k].den) << (QA-1-k);
    always_ff @(posedge clk) begin
      if (rst) va[k+1] <= 1'b0;
      else va[k+1] <= va[k];
      ia[k+1] <= ia[k];
      if ((DIV_W+QA)'(ra[k]) >= dsh) begin
        ra[k+1] <= ra[k] - DIV_W'(dsh);
        qa[k+1] <= qa[k] | (QA'(1) << (QA-1-k));
      end else begin
        ra[k+1] <= ra[k];
        qa[k+1] <= qa[k];
      end
    end
  end

  // Resolve magnitude, then multiply coordinate by it
  logic vm; item_t im; logic [15:0] m;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else vm <= va[QA];
    im <= ia[QA];
    if (ia[QA].is_zero) m <= '0;
    else if (ia[QA].need_div)
      m <= (qa[QA] > QA'(ONE_Q15)) ? ONE_Q15 : qa[QA][15:0];
    else m <= ia[QA].mag;
  end

  localparam int PW = 34;
  logic vp; item_t ip; logic [15:0] mp;
  logic [PW-1:0] pxa, pya;
  logic [15:0] ax, ay;
  assign ax = im.x[15] ? 16'(-im.x) : 16'(im.x);
  assign ay = im.y[15] ? 16'(-im.y) : 16'(im.y);
  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else vp <= vm;
    ip <= im; mp <= m;
    pxa <= ((PW'(ax) * PW'(m)) << 1) + PW'(im.len >> 1);
    pya <= ((PW'(ay) * PW'(m)) << 1) + PW'(im.len >> 1);
  end

  // Stage group B: divide by length, quotient limited to 17 bits
  localparam int QB = 17;
  logic [PW-1:0] rx [0:QB], ry [0:QB];
  logic [QB-1:0] qx [0:QB], qy [0:QB];
  item_t ib [0:QB]; logic [15:0] mb [0:QB]; logic vb [0:QB];
  assign rx[0] = pxa; assign ry[0] = pya;
  assign qx[0] = '0; assign qy[0] = '0;
  assign ib[0] = ip; assign mb[0] = mp; assign vb[0] = vp;
  for (genvar k = 0; k < QB; k++) begin : g_db
    logic [PW+QB-1:0] dsh;
    assign dsh = (PW+QB)'(ib[k].len) << (QB-1-k);
    always_ff @(posedge clk) begin
      if (rst) vb[k+1] <= 1'b0;
      else vb[k+1] <= vb[k];
      ib[k+1] <= ib[k]; mb[k+1] <= mb[k];
      if ((PW+QB)'(rx[k]) >= dsh) begin
        rx[k+1] <= rx[k] - PW'(dsh); qx[k+1] <= qx[k] | (QB'(1) << (QB-1-k));
      end else begin
        rx[k+1] <= rx[k]; qx[k+1] <= qx[k];
      end
      if ((PW+QB)'(ry[k]) >= dsh) begin
        ry[k+1] <= ry[k] - PW'(dsh); qy[k+1] <= qy[k] | (QB'(1) << (QB-1-k));
      end else begin
        ry[k+1] <= ry[k]; qy[k+1] <= qy[k];
      end
    end
  end

  // CORDIC vectoring, one micro-rotation per stage
  logic signed [CW-1:0] cxr [0:NSTG], cyr [0:NSTG];
  logic [31:0] cz [0:NSTG];
  logic signed [CW-1:0] x8, y8;
  assign x8 = CW'(ib[QB].x) <<< 8;
  assign y8 = CW'(ib[QB].y) <<< 8;
  assign cxr[0] = x8[CW-1] ? -x8 : x8;
  assign cyr[0] = x8[CW-1] ? -y8 : y8;
  assign cz[0] = x8[CW-1] ? HALF_TURN : 32'h0;
  logic [15:0] fx [0:NSTG], fy [0:NSTG], fm [0:NSTG];
  logic fv [0:NSTG];
  logic fz [0:NSTG];
  function automatic logic [15:0] fix_coord(input logic sgn, input logic [QB-1:0] q,
                                            input logic [15:0] mm);
    logic [15:0] r;
    if (mm == 0) r = '0;
    else if (sgn) r = 16'(-q);
    else r = (q > QB'(32767)) ? 16'h7FFF : q[15:0];
    return r;
  endfunction
  assign fx[0] = fix_coord(ib[QB].x[15], qx[QB], mb[QB]);
  assign fy[0] = fix_coord(ib[QB].y[15], qy[QB], mb[QB]);
  assign fm[0] = mb[QB];
  assign fv[0] = vb[QB];
  assign fz[0] = ib[QB].is_zero;
  for (genvar k = 0; k < NSTG; k++) begin : g_cr
    always_ff @(posedge clk) begin
      if (rst) fv[k+1] <= 1'b0;
      else fv[k+1] <= fv[k];
      fx[k+1] <= fx[k]; fy[k+1] <= fy[k]; fm[k+1] <= fm[k]; fz[k+1] <= fz[k];
      if (!cyr[k][CW-1]) begin
        cxr[k+1] <= cxr[k] + (cyr[k] >>> k);
        cyr[k+1] <= cyr[k] - (cxr[k] >>> k);
        cz[k+1] <= cz[k] + atan_turn(k);
      end else begin
        cxr[k+1] <= cxr[k] - (cyr[k] >>> k);
        cyr[k+1] <= cyr[k] + (cxr[k] >>> k);
        cz[k+1] <= cz[k] - atan_turn(k);
      end
    end
  end

  // Round the angle; a zero vector has angle zero
  logic [31:0] zr;
  assign zr = cz[NSTG] + 32'h8000;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= fv[NSTG];
    cx <= fx[NSTG]; cy <= fy[NSTG]; cmag <= fm[NSTG];
    angle <= fz[NSTG] ? 16'h0 : zr[31:16];
  end
endmodule
`default_nettype wire

>>> src/rdz_checker.sv
// Port-level checker for the radial dead-zone block, bound to the top level
`default_nettype none
module rdz_checker
  import rdz_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic signed [15:0] corrected_x,
  input wire logic signed [15:0] corrected_y,
  input wire logic [15:0] corrected_magnitude
);
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> corrected_magnitude <= ONE_Q15) else $error("magnitude above one");
  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    done && corrected_magnitude == 0 |-> corrected_x == 0 && corrected_y == 0)
    else $error("nonzero output with zero magnitude");
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
endmodule

bind radial_deadzone_joystick rdz_checker u_rdz_checker (.clk(clk), .rst(rst),
  .start(start), .busy(busy), .done(done), .corrected_x(corrected_x),
  .corrected_y(corrected_y), .corrected_magnitude(corrected_magnitude));
`default_nettype wire

>>> sim/radial_deadzone_joystick_test.sv
// Testbench for radial_deadzone_joystick: directed table, then random samples checked by a predictor
`default_nettype none
module radial_deadzone_joystick_test;
  import rdz_pkg::*;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0] mag;
    logic [15:0] ang;
  } stick_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic typed;
    stick_out_t res;
  } stick_row_t;

  localparam int WATCHDOG = 5000;
  localparam int DRAIN = 120;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [THR_W-1:0] cfg_data;
  logic done;
  logic signed [15:0] corrected_x;
  logic signed [15:0] corrected_y;
  logic [15:0] corrected_magnitude;
  logic [15:0] stick_angle;

  radial_deadzone_joystick DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_x(raw_x), .raw_y(raw_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .corrected_x(corrected_x), .corrected_y(corrected_y),
    .corrected_magnitude(corrected_magnitude), .stick_angle(stick_angle)
  );

  // Shadow copies of the threshold registers
  logic [THR_W-1:0] inner_shadow;
  logic [THR_W-1:0] outer_shadow;

  stick_out_t pending_q[$];
  int mismatches;
  int idle_cycles;
  bit row_typed;
  stick_out_t row_res;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t[24];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
          32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] vector_angle(input longint sx, input longint sy);
    logic [31:0] z;
    longint dx;
    longint dy;
    z = 32'h0;
    sx = sx * 256;
    sy = sy * 256;
    if (sx < 0) begin
      sx = -sx;
      sy = -sy;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = sy >>> i;
      dy = sx >>> i;
      if (sy >= 0) begin
        sx = sx + dx;
        sy = sy - dy;
        z = z + atan_step(i);
      end else begin
        sx = sx - dx;
        sy = sy + dy;
        z = z - atan_step(i);
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic logic [15:0] scale_coord(input longint c, input longint unsigned m,
                                              input longint unsigned len);
    longint unsigned a;
    longint unsigned q;
    a = (c < 0) ? -c : c;
    q = (a * m * 2 + len / 2) / len;
    if (c < 0) return 16'(-longint'(q));
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  // Compute the corrected stick output for one raw sample
  function automatic stick_out_t correct_stick(input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic [THR_W-1:0] inner,
                                               input logic [THR_W-1:0] outer);
    stick_out_t r;
    longint sx;
    longint sy;
    longint unsigned len;
    longint unsigned m;
    longint unsigned d;
    r = '0;
    sx = x;
    sy = y;
    if (sx == 0 && sy == 0) return r;
    len = floor_sqrt(4 * longint'(sx * sx + sy * sy));
    if (len <= inner) begin
      m = 0;
    end else if (outer <= inner || len >= outer) begin
      m = 32768;
    end else begin
      d = outer - inner;
      m = ((len - inner) * 32768 + d / 2) / d;
      if (m > 32768) m = 32768;
    end
    if (m != 0) begin
      r.cx = scale_coord(sx, m, len);
      r.cy = scale_coord(sy, m, len);
    end
    r.mag = 16'(m);
    r.ang = vector_angle(sx, sy);
    return r;
  endfunction

  // Track transfers, config writes and results at each edge
  always @(posedge clk) begin
    stick_out_t e;
    if (rst) begin
      inner_shadow <= '0;
      outer_shadow <= 17'd65536;
      idle_cycles <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INNER) inner_shadow <= cfg_data;
        else outer_shadow <= cfg_data;
      end
      if (start && !busy) begin
        if (row_typed) pending_q.push_back(row_res);
        else pending_q.push_back(correct_stick(raw_x, raw_y, inner_shadow, outer_shadow));
      end
      if (done) begin
        if (pending_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result x=%0d y=%0d", corrected_x, corrected_y);
        end else begin
          e = pending_q.pop_front();
          if (e != {corrected_x, corrected_y, corrected_magnitude, stick_angle}) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch exp x=%0d y=%0d m=%0d a=%0d got x=%0d y=%0d m=%0d a=%0d",
                       e.cx, e.cy, e.mag, e.ang, corrected_x, corrected_y,
                       corrected_magnitude, stick_angle);
          end
        end
      end
      // Watchdog on cycles with no transfer and no result
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("radial_deadzone_joystick_test failed");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input bit typed, input stick_out_t res);
    int gap;
    raw_x <= x;
    raw_y <= y;
    row_typed <= typed;
    row_res <= res;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    // Insert an idle burst now and then
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_thresholds(input logic [THR_W-1:0] inner, input logic [THR_W-1:0] outer);
    start <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_INNER;
    cfg_data <= inner;
    @(posedge clk);
    cfg_index <= REG_OUTER;
    cfg_data <= outer;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(input int span);
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  stick_row_t table_rows[$];

  initial begin
    logic [THR_W-1:0] inner_set[9];
    logic [THR_W-1:0] outer_set[9];
    logic signed [15:0] x;
    logic signed [15:0] y;
    int pick;
    int span;
    rst = 1'b1;
    start = 1'b0;
    raw_x = '0;
    raw_y = '0;
    cfg_we = 1'b0;
    cfg_index = REG_INNER;
    cfg_data = '0;
    row_typed = 1'b0;
    row_res = '0;
    mismatches = 0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: zero vector typed in, the rest predicted
    table_rows = '{
      '{16'sd0, 16'sd0, 1'b1, '0},
      '{16'sd32767, 16'sd0, 1'b0, '0},
      '{-16'sd32768, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd32767, 1'b0, '0},
      '{16'sd0, -16'sd32768, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 1'b0, '0},
      '{16'sd1, 16'sd0, 1'b0, '0},
      '{-16'sd1, 16'sd0, 1'b0, '0},
      '{16'sd0, -16'sd1, 1'b0, '0},
      '{-16'sd1, -16'sd1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, '0},
      '{16'sd16384, 16'sd16384, 1'b0, '0},
      '{-16'sd100, 16'sd0, 1'b0, '0},
      '{-16'sd100, -16'sd5, 1'b0, '0}
    };
    foreach (table_rows[i])
      send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].typed, table_rows[i].res);

    inner_set = '{17'd0, 17'd16384, 17'd65536, 17'd40000, 17'd0, 17'd65535,
                  17'd131071, 17'd8000, 17'd0};
    outer_set = '{17'd65536, 17'd49152, 17'd65536, 17'd20000, 17'd1, 17'd65536,
                  17'd0, 17'd131071, 17'd65536};
    for (int p = 0; p < 9; p++) begin
      write_thresholds(inner_set[p], outer_set[p]);
      if (p == 8) gaps_on = 1'b0;
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 9);
        span = (pick < 4) ? 32767 : (pick < 7) ? 2000 : (pick < 8) ? 30 : 0;
        if (span == 0) begin
          // Extremes, axes and the zero vector
          x = ($urandom_range(0, 2) == 0) ? 16'sd0 : ($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768);
          y = ($urandom_range(0, 2) == 0) ? 16'sd0 : ($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768);
        end else begin
          x = (span == 32767) ? 16'($urandom) : rand_coord(span);
          y = (span == 32767) ? 16'($urandom) : rand_coord(span);
        end
        send_sample(x, y, 1'b0, '0);
      end
    end
    start <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("radial_deadzone_joystick_test passed");
    end else begin
      $display("radial_deadzone_joystick_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
